/* hdl/quaternion_axis_angle_rotate_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion rotate block
// Each check uses the clk and rst of the module that includes this header.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_AXIS_ANGLE_ROTATE_MACROS_SVH
`define QUATERNION_AXIS_ANGLE_ROTATE_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition holds in the same cycle
`define QAAR_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define QAAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QAAR_ASSERT_NOW(lbl, cond)
`define QAAR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/qaar_pkg.sv */
// ----------------------------------------------------------------------------
// qaar_pkg
// Shared constants, types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package qaar_pkg;

  // CORDIC iteration count, 8 to 24
  localparam int CORDIC_STEPS = 16;

  // CORDIC datapath width: Q2.30 plus headroom
  localparam int CW = 34;
  // quaternion component width (Q.24) and first product width (Q16.16)
  localparam int AW = 28;
  localparam int PW = 38;

  // start value of x, 1/gain in Q2.30
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // reciprocals of 45: coarse one for mag/45, fine one for the remainder part
  localparam logic [17:0] INV45_COARSE = 18'd186414;
  localparam logic [26:0] INV45_FINE   = 27'd95443718;
  localparam logic [5:0]  DEG_DIV      = 6'd45;

  typedef logic signed [CW-1:0] cord_t;
  typedef logic signed [AW-1:0] qa_t;
  typedef logic signed [PW-1:0] qp_t;

  // vector and axis riding along with the angle
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } qaar_side_t;

  // atan(2^-i) as a binary angle, full circle = 2^32
  function automatic logic [31:0] atan_bam(input int idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'h20000000;
      1:       val = 32'h12E4051E;
      2:       val = 32'h09FB385B;
      3:       val = 32'h051111D4;
      4:       val = 32'h028B0D43;
      5:       val = 32'h0145D7E1;
      6:       val = 32'h00A2F61E;
      7:       val = 32'h00517C55;
      8:       val = 32'h0028BE53;
      9:       val = 32'h00145F2F;
      10:      val = 32'h000A2F98;
      11:      val = 32'h000517CC;
      12:      val = 32'h00028BE6;
      13:      val = 32'h000145F3;
      14:      val = 32'h0000A2FA;
      15:      val = 32'h0000517D;
      16:      val = 32'h000028BE;
      17:      val = 32'h0000145F;
      18:      val = 32'h00000A30;
      19:      val = 32'h00000518;
      20:      val = 32'h0000028C;
      21:      val = 32'h00000146;
      22:      val = 32'h000000A3;
      23:      val = 32'h00000051;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

/* hdl/qaar_angle.sv */
// ----------------------------------------------------------------------------
// qaar_angle
// Degrees to half-angle binary angle, folded into +/-90 degrees. Three stages.
// ----------------------------------------------------------------------------
`include "quaternion_axis_angle_rotate_macros.svh"

module qaar_angle import qaar_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [16:0] angle_deg,
  input  qaar_side_t         side_in,
  output logic               valid,
  output cord_t              z,
  output logic               neg,
  output qaar_side_t         side
);

  // stage 1: magnitude and coarse quotient mag/45
  logic signed [17:0] ang_ext;
  logic signed [17:0] mag_s;
  logic [16:0]        mag;
  logic [34:0]        q_prod;
  logic               v1;
  logic [16:0]        mag1;
  logic [10:0]        q1;
  logic               sgn1;
  qaar_side_t         side1;

  always_comb begin
    ang_ext = 18'(angle_deg);
    mag_s   = angle_deg[16] ? -ang_ext : ang_ext;
    mag     = mag_s[16:0];
    q_prod  = 35'(mag) * 35'(INV45_COARSE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1  <= mag;
      q1    <= q_prod[33:23];
      sgn1  <= angle_deg[16];
      side1 <= side_in;
    end
  end

  // stage 2: hb = q*2^21 + round(r*2^21/45), i.e. round(mag*2^24/360)
  logic [16:0] rem_full;
  logic [5:0]  rem;
  logic [26:0] num;
  logic [53:0] f_prod;
  logic [20:0] frac;
  logic [31:0] hb;
  logic        v2;
  logic [31:0] hb2;
  logic        sgn2;
  qaar_side_t  side2;

  always_comb begin
    rem_full = mag1 - 17'(17'(q1) * 17'(DEG_DIV));
    rem      = rem_full[5:0];
    num      = {rem, 21'd0} + 27'd22;
    f_prod   = 54'(num) * 54'(INV45_FINE);
    frac     = f_prod[52:32];
    hb       = {q1, 21'd0} + 32'(frac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hb2   <= hb;
      sgn2  <= sgn1;
      side2 <= side1;
    end
  end

  // stage 3: apply sign, fold quadrants 1 and 2 by a half turn
  logic [31:0] t;
  logic        fold;
  logic [31:0] tf;

  always_comb begin
    t    = sgn2 ? (32'd0 - hb2) : hb2;
    fold = t[31] ^ t[30];
    tf   = {t[31] ^ fold, t[30:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z    <= CW'($signed(tf));
      neg  <= fold;
      side <= side2;
    end
  end

  // checks
  `QAAR_ASSERT_NEXT(a_valid_moves, v1 && adv, v2)
  `QAAR_ASSERT_NOW(a_fold_range, !valid || z[CW-1:30] == '0 || z[CW-1:30] == '1)

endmodule

/* hdl/qaar_cordic.sv */
// ----------------------------------------------------------------------------
// qaar_cordic
// Rotation-mode CORDIC, one register stage per iteration.
// ----------------------------------------------------------------------------
`include "quaternion_axis_angle_rotate_macros.svh"

module qaar_cordic import qaar_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       in_valid,
  input  cord_t      z_in,
  input  logic       neg_in,
  input  qaar_side_t side_in,
  output logic       valid,
  output cord_t      x,
  output cord_t      y,
  output logic       neg,
  output qaar_side_t side
);

  localparam cord_t ZRES = CW'(atan_bam(CORDIC_STEPS - 1)) <<< 1;

  logic       vld [1:CORDIC_STEPS];
  cord_t      xs  [1:CORDIC_STEPS];
  cord_t      ys  [1:CORDIC_STEPS];
  cord_t      zs  [1:CORDIC_STEPS];
  logic       ng  [1:CORDIC_STEPS];
  qaar_side_t sd  [1:CORDIC_STEPS];
  cord_t      z_res;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic       vi;
    cord_t      xi;
    cord_t      yi;
    cord_t      zi;
    logic       ni;
    qaar_side_t si;
    cord_t      xsh;
    cord_t      ysh;
    cord_t      ang;

    // stage input: block input for the first iteration
    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z_in;
      assign ni = neg_in;
      assign si = side_in;
    end else begin : g_next
      assign vi = vld[i];
      assign xi = xs[i];
      assign yi = ys[i];
      assign zi = zs[i];
      assign ni = ng[i];
      assign si = sd[i];
    end

    assign xsh = xi >>> i;
    assign ysh = yi >>> i;
    assign ang = CW'(atan_bam(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vi;
      end
    end

    // one micro-rotation toward z = 0
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!zi[CW-1]) begin
          xs[i+1] <= xi - ysh;
          ys[i+1] <= yi + xsh;
          zs[i+1] <= zi - ang;
        end else begin
          xs[i+1] <= xi + ysh;
          ys[i+1] <= yi - xsh;
          zs[i+1] <= zi + ang;
        end
        ng[i+1] <= ni;
        sd[i+1] <= si;
      end
    end
  end

  assign valid = vld[CORDIC_STEPS];
  assign x     = xs[CORDIC_STEPS];
  assign y     = ys[CORDIC_STEPS];
  assign neg   = ng[CORDIC_STEPS];
  assign side  = sd[CORDIC_STEPS];
  assign z_res = zs[CORDIC_STEPS];

  // residual angle must have converged
  `QAAR_ASSERT_NOW(a_residual, !valid || (z_res <= ZRES && z_res >= -ZRES))

endmodule

/* hdl/qaar_hamilton.sv */
// ----------------------------------------------------------------------------
// qaar_hamilton
// Builds Qa from sin/cos and axis, then Qa*(0,v)*conj(Qa), saturated.
// Five stages: quaternion, products, sums, products, sums and saturation.
// ----------------------------------------------------------------------------
module qaar_hamilton import qaar_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  cord_t              x,
  input  cord_t              y,
  input  logic               neg,
  input  qaar_side_t         side,
  output logic               valid,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z,
  output logic               overflow
);

  // stage 1: quaternion components in Q.24
  cord_t              xn;
  cord_t              yn;
  cord_t              a0_full;
  logic signed [49:0] mx;
  logic signed [49:0] my;
  logic signed [49:0] mz;
  logic               v1;
  qa_t                a1r [0:3];
  logic signed [31:0] vx1;
  logic signed [31:0] vy1;
  logic signed [31:0] vz1;

  always_comb begin
    xn      = neg ? -x : x;
    yn      = neg ? -y : y;
    a0_full = (xn + 34'sd32) >>> 6;
    mx      = 50'(side.ax) * 50'(yn);
    my      = 50'(side.ay) * 50'(yn);
    mz      = 50'(side.az) * 50'(yn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1r[0] <= AW'(a0_full);
      a1r[1] <= AW'((mx + 50'sd524288) >>> 20);
      a1r[2] <= AW'((my + 50'sd524288) >>> 20);
      a1r[3] <= AW'((mz + 50'sd524288) >>> 20);
      vx1    <= side.vx;
      vy1    <= side.vy;
      vz1    <= side.vz;
    end
  end

  // stage 2: products of Qa with (0, v)
  logic               v2;
  logic signed [59:0] m [0:11];
  qa_t                a2r [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m[0]  <= 60'(a1r[1]) * 60'(vx1);
      m[1]  <= 60'(a1r[2]) * 60'(vy1);
      m[2]  <= 60'(a1r[3]) * 60'(vz1);
      m[3]  <= 60'(a1r[0]) * 60'(vx1);
      m[4]  <= 60'(a1r[2]) * 60'(vz1);
      m[5]  <= 60'(a1r[3]) * 60'(vy1);
      m[6]  <= 60'(a1r[0]) * 60'(vy1);
      m[7]  <= 60'(a1r[1]) * 60'(vz1);
      m[8]  <= 60'(a1r[3]) * 60'(vx1);
      m[9]  <= 60'(a1r[0]) * 60'(vz1);
      m[10] <= 60'(a1r[1]) * 60'(vy1);
      m[11] <= 60'(a1r[2]) * 60'(vx1);
      a2r   <= a1r;
    end
  end

  // stage 3: sum and round to Q16.16
  logic signed [61:0] s [0:3];
  logic               v3;
  qp_t                p [0:3];
  qa_t                a3r [0:3];

  always_comb begin
    s[0] = -(62'(m[0]) + 62'(m[1]) + 62'(m[2]));
    s[1] = 62'(m[3]) + 62'(m[4]) - 62'(m[5]);
    s[2] = 62'(m[6]) - 62'(m[7]) + 62'(m[8]);
    s[3] = 62'(m[9]) + 62'(m[10]) - 62'(m[11]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        p[k] <= PW'((s[k] + 62'sd8388608) >>> 24);
      end
      a3r <= a2r;
    end
  end

  // stage 4: products of P with conj(Qa)
  logic               v4;
  logic signed [65:0] n [0:11];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n[0]  <= 66'(p[0]) * 66'(a3r[1]);
      n[1]  <= 66'(p[1]) * 66'(a3r[0]);
      n[2]  <= 66'(p[2]) * 66'(a3r[3]);
      n[3]  <= 66'(p[3]) * 66'(a3r[2]);
      n[4]  <= 66'(p[0]) * 66'(a3r[2]);
      n[5]  <= 66'(p[1]) * 66'(a3r[3]);
      n[6]  <= 66'(p[2]) * 66'(a3r[0]);
      n[7]  <= 66'(p[3]) * 66'(a3r[1]);
      n[8]  <= 66'(p[0]) * 66'(a3r[3]);
      n[9]  <= 66'(p[1]) * 66'(a3r[2]);
      n[10] <= 66'(p[2]) * 66'(a3r[1]);
      n[11] <= 66'(p[3]) * 66'(a3r[0]);
    end
  end

  // stage 5: sum, round, saturate into the output register
  logic signed [67:0] t [0:2];
  logic signed [43:0] r [0:2];
  logic signed [31:0] sat [0:2];
  logic [2:0]         clip;

  always_comb begin
    t[0] = -68'(n[0]) + 68'(n[1]) - 68'(n[2]) + 68'(n[3]);
    t[1] = -68'(n[4]) + 68'(n[5]) + 68'(n[6]) - 68'(n[7]);
    t[2] = -68'(n[8]) - 68'(n[9]) + 68'(n[10]) + 68'(n[11]);
    for (int k = 0; k < 3; k++) begin
      r[k] = 44'((t[k] + 68'sd8388608) >>> 24);
      if (r[k] > 44'sd2147483647) begin
        sat[k]  = 32'sh7FFFFFFF;
        clip[k] = 1'b1;
      end else if (r[k] < -44'sd2147483648) begin
        sat[k]  = 32'sh80000000;
        clip[k] = 1'b1;
      end else begin
        sat[k]  = 32'(r[k]);
        clip[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_x    <= sat[0];
      rot_y    <= sat[1];
      rot_z    <= sat[2];
      overflow <= |clip;
    end
  end

endmodule

/* hdl/quaternion_axis_angle_rotate.sv */
// Path from input transfer to result: angle stages, CORDIC iteration stages, then Hamilton stages.
// Throughput: one item per cycle while the receiver takes results; a single enable, set
// by the output register being empty or taken, advances every stage together.
// Reset: synchronous rst clears all stage valid bits; no result is pending.
// ----------------------------------------------------------------------------
// quaternion_axis_angle_rotate
// Rotates a Q16.16 vector about an unnormalized Q2.14 axis by a Q10.7 angle.
// ----------------------------------------------------------------------------
`include "quaternion_axis_angle_rotate_macros.svh"

module quaternion_axis_angle_rotate import qaar_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [16:0] angle_deg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z,
  output logic               overflow
);

  logic       adv;
  qaar_side_t side_in;
  logic       ang_valid;
  cord_t      ang_z;
  logic       ang_neg;
  qaar_side_t ang_side;
  logic       cor_valid;
  cord_t      cor_x;
  cord_t      cor_y;
  logic       cor_neg;
  qaar_side_t cor_side;
  logic       at_rail;

  // whole pipeline moves when the output register is free
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign side_in = '{vx: vec_x, vy: vec_y, vz: vec_z,
                     ax: axis_x, ay: axis_y, az: axis_z};

  qaar_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .angle_deg (angle_deg),
    .side_in   (side_in),
    .valid     (ang_valid),
    .z         (ang_z),
    .neg       (ang_neg),
    .side      (ang_side)
  );

  qaar_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (ang_valid),
    .z_in     (ang_z),
    .neg_in   (ang_neg),
    .side_in  (ang_side),
    .valid    (cor_valid),
    .x        (cor_x),
    .y        (cor_y),
    .neg      (cor_neg),
    .side     (cor_side)
  );

  qaar_hamilton u_hamilton (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (cor_valid),
    .x        (cor_x),
    .y        (cor_y),
    .neg      (cor_neg),
    .side     (cor_side),
    .valid    (out_valid),
    .rot_x    (rot_x),
    .rot_y    (rot_y),
    .rot_z    (rot_z),
    .overflow (overflow)
  );

  // some component sits at a rail
  assign at_rail = rot_x == 32'sh7FFFFFFF || rot_x == 32'sh80000000 ||
                   rot_y == 32'sh7FFFFFFF || rot_y == 32'sh80000000 ||
                   rot_z == 32'sh7FFFFFFF || rot_z == 32'sh80000000;

  // a raised flag means some component sits at a rail
  `QAAR_ASSERT_NOW(a_ovf_rail, !(out_valid && overflow) || at_rail)

endmodule

/* verif/tb_quaternion_axis_angle_rotate.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_axis_angle_rotate
// Drives random and directed vectors, axes and angles into the rotate block
// with bursty input and a stalling receiver, predicts each rotated vector
// with a bit-true CORDIC and Hamilton product model, and compares in order.
// ----------------------------------------------------------------------------
module tb_quaternion_axis_angle_rotate;
  import qaar_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               ovf;
  } rot_res_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] vec_x, vec_y, vec_z;
  logic signed [15:0] axis_x, axis_y, axis_z;
  logic signed [16:0] angle_deg;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] rot_x, rot_y, rot_z;
  logic               overflow;

  // expected results in transfer order; 11-bit pointers wrap with the store
  rot_res_t   exp_mem [0:2047];
  logic [10:0] exp_wr;
  logic [10:0] exp_rd;
  int       n_err;
  int       cyc;
  bit       hold_long;

  quaternion_axis_angle_rotate u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .angle_deg(angle_deg),
    .out_valid(out_valid), .out_ready(out_ready),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // round half up, then floor shift
  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v, inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // bit-true prediction of one rotation
  function automatic rot_res_t rotate_vec(
      input logic signed [31:0] vx, vy, vz,
      input logic signed [15:0] ax, ay, az,
      input logic signed [16:0] ang);
    longint    mag, hb, x, y, z, xs, ys;
    longint    a0, a1, a2, a3, p0, p1, p2, p3, r1, r2, r3;
    logic [31:0] t;
    bit        flip;
    logic      ovf;
    rot_res_t  res;
    mag = (ang < 0) ? -longint'(ang) : longint'(ang);
    hb = ((mag <<< 24) + 180) / 360;
    if (ang < 0) hb = -hb;
    t = hb[31:0];
    flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
    if (flip) t = t + 32'h80000000;
    z = longint'($signed(t));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_bam(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_bam(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    a0 = rnd_shift(x, 6);
    a1 = rnd_shift(longint'(ax) * y, 20);
    a2 = rnd_shift(longint'(ay) * y, 20);
    a3 = rnd_shift(longint'(az) * y, 20);
    p0 = rnd_shift(-a1 * vx - a2 * vy - a3 * vz, 24);
    p1 = rnd_shift(a0 * vx + a2 * vz - a3 * vy, 24);
    p2 = rnd_shift(a0 * vy - a1 * vz + a3 * vx, 24);
    p3 = rnd_shift(a0 * vz + a1 * vy - a2 * vx, 24);
    r1 = rnd_shift(-p0 * a1 + p1 * a0 - p2 * a3 + p3 * a2, 24);
    r2 = rnd_shift(-p0 * a2 + p1 * a3 + p2 * a0 - p3 * a1, 24);
    r3 = rnd_shift(-p0 * a3 - p1 * a2 + p2 * a1 + p3 * a0, 24);
    ovf = 1'b0;
    res.x = clamp32(r1, ovf);
    res.y = clamp32(r2, ovf);
    res.z = clamp32(r3, ovf);
    res.ovf = ovf;
    return res;
  endfunction

  // offer one item, wait for its transfer, store the prediction
  task automatic send_item(input logic signed [31:0] vx, vy, vz,
                           input logic signed [15:0] ax, ay, az,
                           input logic signed [16:0] ang);
    in_valid  <= 1'b1;
    vec_x <= vx; vec_y <= vy; vec_z <= vz;
    axis_x <= ax; axis_y <= ay; axis_z <= az;
    angle_deg <= ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_mem[exp_wr] = rotate_vec(vx, vy, vz, ax, ay, az, ang);
    exp_wr = exp_wr + 11'd1;
  endtask

  // random gap after a burst ends; valid stays high inside a burst
  int burst_left;
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
    burst_left = $urandom_range(0, 20);
  endtask

  function automatic logic signed [16:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 17'($signed($urandom_range(0, 92160)) - 46080);
      1: return 17'($signed($urandom_range(0, 2000)) - 1000);
      2: return 17'($signed($urandom_range(0, 8)) * 1440 - 5760
                   + $signed($urandom_range(0, 2)) - 1);
      default: return 17'($signed($urandom_range(0, 6)) * 11520 - 34560);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_vec();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      2: return {{8{1'b0}}, 24'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic logic signed [15:0] rand_axis();
    if ($urandom_range(0, 2) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic test_extremes();
    logic signed [31:0] vmax, vmin;
    vmax = 32'sh7fffffff;
    vmin = 32'sh80000000;
    burst_left = 0;
    send_item(32'sh10000, 0, 0, 0, 0, 16384, 17'sd11520);
    send_item(32'sh10000, 32'sh20000, -32'sh30000, 16384, 0, 0, 17'sd23040);
    send_item(vmax, vmax, vmax, 16'sh7fff, 16'sh7fff, 16'sh7fff, 17'sd46080);
    send_item(vmin, vmin, vmin, 16'sh8000, 16'sh8000, 16'sh8000, -17'sd46080);
    send_item(vmax, vmin, 0, 16'sh8000, 16'sh7fff, 0, 17'sd5760);
    send_item(vmin, vmax, vmax, 0, 16'sh8000, 16'sh7fff, -17'sd5760);
    // zero axis scales by cos squared
    send_item(32'sh123456, -32'sh654321, 32'sh7fff, 0, 0, 0, 17'sd7000);
    send_item(32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0, 17'sd0);
    // half angle in the folded range, boundary at +/-180 degrees, then +/-270 degrees
    send_item(32'sh10000, 32'sh10000, 0, 0, 16384, 0, 17'sd23041);
    send_item(32'sh10000, 32'sh10000, 0, 0, 16384, 0, 17'sd23039);
    send_item(32'sh10000, 0, 32'sh10000, 9459, 9459, 9459, 17'sd34560);
    send_item(32'sh10000, 0, 32'sh10000, 9459, 9459, 9459, -17'sd34560);
    send_item(32'sh10000, 0, 32'sh10000, 9459, -9459, 9459, -17'sd23040);
    send_item(-32'sh1, 32'sh1, -32'sh1, -16384, -16384, 16384, 17'sd1);
    send_item(-32'sh1, 32'sh1, -32'sh1, -16384, -16384, 16384, -17'sd1);
    send_item(32'sh5a5a5a5a, -32'sh5a5a5a5a, 32'sh0000ffff, 16'sh5555, 16'shaaaa,
              16'sh0001, 17'sh0aaaa);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_random(input int count);
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      send_item(rand_vec(), rand_vec(), rand_vec(),
                rand_axis(), rand_axis(), rand_axis(), rand_angle());
      pace();
    end
    in_valid <= 1'b0;
  endtask

  // sender keeps offering while the receiver holds off
  task automatic test_backpressure();
    @(posedge clk);
    hold_long = 1'b1;
    burst_left = 200;
    for (int i = 0; i < 60; i++) begin
      send_item(rand_vec(), rand_vec(), rand_vec(),
                rand_axis(), rand_axis(), rand_axis(), rand_angle());
      burst_left = 200;
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    rot_res_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (exp_rd == exp_wr) begin
        $display("%0t unexpected result %h %h %h %b", $time, rot_x, rot_y, rot_z,
                 overflow);
        n_err++;
      end else begin
        exp_r = exp_mem[exp_rd];
        exp_rd = exp_rd + 11'd1;
        if (rot_x !== exp_r.x) begin
          $display("%0t rot_x expected %h actual %h", $time, exp_r.x, rot_x);
          n_err++;
        end
        if (rot_y !== exp_r.y) begin
          $display("%0t rot_y expected %h actual %h", $time, exp_r.y, rot_y);
          n_err++;
        end
        if (rot_z !== exp_r.z) begin
          $display("%0t rot_z expected %h actual %h", $time, exp_r.z, rot_z);
          n_err++;
        end
        if (overflow !== exp_r.ovf) begin
          $display("%0t overflow expected %b actual %b", $time, exp_r.ovf, overflow);
          n_err++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    n_err = 0;
    cyc = 0;
    hold_long = 1'b0;
    exp_wr = '0;
    exp_rd = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    vec_x = '0; vec_y = '0; vec_z = '0;
    axis_x = '0; axis_y = '0; axis_z = '0;
    angle_deg = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random(500);
    test_backpressure();
    test_random(480);
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (CORDIC_STEPS + 20) @(posedge clk);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
